// ===== hw/rtl/fmv_pkg.sv =====
// Package for the two-operator FM voice: operator state record, register
// indexes, reset values and the sine table generator.
// No dependencies.
package fmv_pkg;

   localparam int unsigned SINE_DEPTH_DEF      = 256;
   localparam int unsigned CARRIER_SUSTAIN_DEF = 1;
   localparam int unsigned MOD_SUSTAIN_DEF     = 0;

   localparam int unsigned PHASE_W = 32;
   localparam int unsigned LEVEL_W = 26;
   localparam int unsigned LEN_W   = 20;
   localparam int unsigned SUS_W   = 16;
   localparam int unsigned TIMER_W = 24;
   localparam int unsigned SMP_W   = 12;
   localparam int unsigned SINE_W  = 16;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
   localparam logic [SMP_W-1:0]   SMP_MID   = 12'd2048;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_ATTACK_LENGTH     = 3'd0;
   localparam logic [2:0] REG_DECAY_LENGTH      = 3'd1;
   localparam logic [2:0] REG_ATTACK_STEP       = 3'd2;
   localparam logic [2:0] REG_DECAY_STEP        = 3'd3;
   localparam logic [2:0] REG_MOD_ATTACK_LENGTH = 3'd4;
   localparam logic [2:0] REG_MOD_DECAY_LENGTH  = 3'd5;
   localparam logic [2:0] REG_MOD_ATTACK_STEP   = 3'd6;
   localparam logic [2:0] REG_MOD_DECAY_STEP    = 3'd7;

   localparam logic [LEN_W-1:0]   ATTACK_LENGTH_RST     = 20'd250;
   localparam logic [LEN_W-1:0]   DECAY_LENGTH_RST      = 20'd50000;
   localparam logic [LEVEL_W-1:0] ATTACK_STEP_RST       = 26'd262144;
   localparam logic [LEVEL_W-1:0] DECAY_STEP_RST        = 26'd1310;
   localparam logic [LEN_W-1:0]   MOD_ATTACK_LENGTH_RST = 20'd2000;
   localparam logic [LEN_W-1:0]   MOD_DECAY_LENGTH_RST  = 20'd40000;
   localparam logic [LEVEL_W-1:0] MOD_ATTACK_STEP_RST   = 26'd32768;
   localparam logic [LEVEL_W-1:0] MOD_DECAY_STEP_RST    = 26'd1638;

   // Operator RAM entries
   localparam int unsigned NUM_OPS = 2;
   localparam logic OP_MOD = 1'b0;
   localparam logic OP_CAR = 1'b1;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [LEVEL_W-1:0] level;
   } op_state_type;

   typedef struct packed {
      logic         rd_en;
      logic         rd_addr;
      logic         wr_en;
      logic         wr_addr;
      op_state_type wr_data;
   } ram_cmd_type;

   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Q1.15 sine of a quarter-turn angle in Q30; quad[0] picks the cosine
   // series, quad[1] negates. Eight Taylor terms, Q30 throughout.
   function automatic logic signed [SINE_W-1:0] sine_q15(logic [63:0] ang,
                                                          logic [1:0] quad);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        mag;
      logic [63:0]        r;
      logic               neg;
      x2  = (ang * ang) >> 30;
      if (quad[0]) begin
         term = ONE_Q30;
         sum  = $signed(term);
         term = ((term * x2) >> 30) / 2;   sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 12;  sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 30;  sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 56;  sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 90;  sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 132; sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 182; sum = sum - $signed(term);
      end else begin
         term = ang;
         sum  = $signed(term);
         term = ((term * x2) >> 30) / 6;   sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 20;  sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 42;  sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 72;  sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 110; sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 156; sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 210; sum = sum - $signed(term);
      end
      if (quad[1]) begin
         sum = -sum;
      end
      neg = sum[63];
      mag = neg ? $unsigned(-sum) : $unsigned(sum);
      r   = (mag + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return neg ? -$signed(SINE_W'(r)) : $signed(SINE_W'(r));
   endfunction

endpackage

// ===== hw/rtl/fmv_sine_rom.sv =====
// Sine ROM, Q1.15, registered read. Contents built at elaboration.
// Depends on fmv_pkg.
module fmv_sine_rom import fmv_pkg::*; #(
   parameter int unsigned SINE_DEPTH = SINE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(SINE_DEPTH)-1:0] rd_addr,
   output logic signed [SINE_W-1:0]      rd_data
);

   logic signed [SINE_W-1:0] sine_tbl [SINE_DEPTH];
   logic signed [SINE_W-1:0] rd_data_ff;

   for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_tbl
      localparam int unsigned QUAD = (4 * g) / SINE_DEPTH;
      localparam int unsigned REM  = (4 * g) % SINE_DEPTH;
      localparam logic [63:0] ANG  = (HALF_PI_Q30 * 64'(REM)) / 64'(SINE_DEPTH);
      assign sine_tbl[g] = sine_q15(ANG, 2'(QUAD));
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= sine_tbl[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fmv_op_ram.sv =====
// Operator state RAM: phase and envelope level for modulator and carrier.
// One read and one write port, registered read; unwritten entries read zero.
// Depends on fmv_pkg.
module fmv_op_ram import fmv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ram_cmd_type  cmd,
   output op_state_type rd_data
);

   op_state_type op_mem [NUM_OPS];
   logic [NUM_OPS-1:0] vld_ff;
   op_state_type       rd_data_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         op_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= op_mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            vld_ff[cmd.wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_vld_ff <= vld_ff[cmd.rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/fmv_envelope.sv =====
// Linear attack / sustain / decay level update for one operator tick.
// Depends on fmv_pkg.
module fmv_envelope import fmv_pkg::*; (
   input  logic [LEVEL_W-1:0] level,
   input  logic [TIMER_W-1:0] ticks,
   input  logic [LEN_W-1:0]   att_len,
   input  logic [LEN_W-1:0]   dec_len,
   input  logic [SUS_W-1:0]   sus_len,
   input  logic [LEVEL_W-1:0] up_step,
   input  logic [LEVEL_W-1:0] down_step,
   output logic [LEVEL_W-1:0] level_out
);

   logic [LEN_W+1:0]   total_len;
   logic [LEN_W:0]     hold_end;
   logic [LEVEL_W:0]   rise;

   always_comb begin
      total_len = (LEN_W+2)'(att_len) + (LEN_W+2)'(dec_len) + (LEN_W+2)'(sus_len);
      hold_end  = (LEN_W+1)'(att_len) + (LEN_W+1)'(sus_len);
      rise      = (LEVEL_W+1)'(level) + (LEVEL_W+1)'(up_step);
      if (TIMER_W'(total_len) <= ticks) begin
         level_out = '0;
      end else if (ticks <= TIMER_W'(att_len)) begin
         level_out = rise[LEVEL_W] ? LEVEL_MAX : rise[LEVEL_W-1:0];
      end else if (ticks <= TIMER_W'(hold_end)) begin
         level_out = level;
      end else begin
         level_out = (level > down_step) ? level - down_step : '0;
      end
   end

endmodule

// ===== hw/rtl/fm_dds_voice_with_envelope_top.sv =====
// Two-operator FM voice with linear envelopes. Play tick: states MOD, FM, CAR,
// SMP, result registered in SMP, which waits on a stalled output; note on:
// NOTE_MOD, NOTE_CAR; phase-only tick: PHASE. Requests are taken only in IDLE.
// The order follows the operator RAM read-modify-write and the one shared multiplier.
// Synchronous active-high reset: RAM entries read as zero, timer saturated.
// Depends on fmv_pkg, fmv_op_ram, fmv_sine_rom, fmv_envelope.
module fm_dds_voice_with_envelope_top import fmv_pkg::*; #(
   parameter int unsigned SINE_DEPTH      = SINE_DEPTH_DEF,
   parameter int unsigned CARRIER_SUSTAIN = CARRIER_SUSTAIN_DEF,
   parameter int unsigned MOD_SUSTAIN     = MOD_SUSTAIN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // phase_step[31:0], synth_on[32], zero pad
   input  logic         req_tuser,   // action: 0 tick, 1 note on
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // dac_sample[11:0], zero pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [25:0]  csr_data
);

   localparam int unsigned AW = $clog2(SINE_DEPTH);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_MOD      = 8'b0000_0010,
      ST_FM       = 8'b0000_0100,
      ST_CAR      = 8'b0000_1000,
      ST_SMP      = 8'b0001_0000,
      ST_NOTE_MOD = 8'b0010_0000,
      ST_NOTE_CAR = 8'b0100_0000,
      ST_PHASE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]   att_len_ff, dec_len_ff, mod_att_len_ff, mod_dec_len_ff;
   logic [LEVEL_W-1:0] att_step_ff, dec_step_ff, mod_att_step_ff, mod_dec_step_ff;

   logic [PHASE_W-1:0] step_ff, step_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic signed [SMP_W-1:0] fm_ff, fm_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]   rsp_data_ff, rsp_data_in;

   ram_cmd_type  ram_cmd;
   op_state_type ram_rd;

   logic                     rom_rd_en;
   logic [AW-1:0]            rom_addr;
   logic signed [SINE_W-1:0] sine;

   logic [PHASE_W-1:0] mod_phase_nxt, car_phase_nxt, fm_shift;
   logic [SINE_W-2:0]  sine_mag;
   logic [LEVEL_W+SINE_W-2:0] prod;
   logic [SMP_W-2:0]   prod_int;
   logic signed [SMP_W-1:0] scaled;

   logic               env_car;
   logic [LEN_W-1:0]   env_att, env_dec;
   logic [SUS_W-1:0]   env_sus;
   logic [LEVEL_W-1:0] env_up, env_down, env_out;
   logic               out_free;
   logic               req_acc;

   fmv_op_ram u_op_ram (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ram_cmd),
      .rd_data (ram_rd)
   );

   fmv_sine_rom #(.SINE_DEPTH(SINE_DEPTH)) u_sine_rom (
      .clock   (clock),
      .rd_en   (rom_rd_en),
      .rd_addr (rom_addr),
      .rd_data (sine)
   );

   // carrier parameters in the carrier write state, modulator otherwise
   assign env_car  = (state_ff == ST_CAR);
   assign env_att  = env_car ? att_len_ff  : mod_att_len_ff;
   assign env_dec  = env_car ? dec_len_ff  : mod_dec_len_ff;
   assign env_sus  = env_car ? SUS_W'(CARRIER_SUSTAIN) : SUS_W'(MOD_SUSTAIN);
   assign env_up   = env_car ? att_step_ff : mod_att_step_ff;
   assign env_down = env_car ? dec_step_ff : mod_dec_step_ff;

   fmv_envelope u_envelope (
      .level     (ram_rd.level),
      .ticks     (timer_ff),
      .att_len   (env_att),
      .dec_len   (env_dec),
      .sus_len   (env_sus),
      .up_step   (env_up),
      .down_step (env_down),
      .level_out (env_out)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // shared multiplier: level times |sine|, truncated toward zero
   assign sine_mag = sine[SINE_W-1] ? (SINE_W-1)'(-sine) : sine[SINE_W-2:0];
   assign prod     = lvl_ff * sine_mag;
   assign prod_int = prod[LEVEL_W+SINE_W-2:30];
   assign scaled   = sine[SINE_W-1] ? -$signed({1'b0, prod_int}) : $signed({1'b0, prod_int});

   assign mod_phase_nxt = ram_rd.phase + step_ff + {1'b0, step_ff[PHASE_W-1:1]};
   assign fm_shift      = {{4{fm_ff[SMP_W-1]}}, fm_ff, 16'b0};
   assign car_phase_nxt = ram_rd.phase + step_ff + fm_shift;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      timer_in     = timer_ff;
      lvl_in       = lvl_ff;
      fm_in        = fm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_cmd      = '0;
      rom_rd_en    = 1'b0;
      rom_addr     = mod_phase_nxt[PHASE_W-1 -: AW];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = (req_tuser || req_tdata[32]) ? OP_MOD : OP_CAR;
               if (req_tuser) begin
                  step_in  = req_tdata[31:0];
                  timer_in = '0;
                  state_in = ST_NOTE_MOD;
               end else if (req_tdata[32]) begin
                  state_in = ST_MOD;
               end else begin
                  state_in = ST_PHASE;
               end
            end
         end
         ST_NOTE_MOD: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = OP_MOD;
            ram_cmd.wr_data = '{phase: ram_rd.phase, level: '0};
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = OP_CAR;
            state_in        = ST_NOTE_CAR;
         end
         ST_NOTE_CAR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = OP_CAR;
            ram_cmd.wr_data = '{phase: ram_rd.phase, level: '0};
            state_in        = ST_IDLE;
         end
         ST_PHASE: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = OP_CAR;
            ram_cmd.wr_data = '{phase: ram_rd.phase + step_ff, level: ram_rd.level};
            state_in        = ST_IDLE;
         end
         ST_MOD: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = OP_MOD;
            ram_cmd.wr_data = '{phase: mod_phase_nxt, level: env_out};
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = OP_CAR;
            rom_rd_en       = 1'b1;
            lvl_in          = ram_rd.level;
            state_in        = ST_FM;
         end
         ST_FM: begin
            fm_in    = scaled;
            state_in = ST_CAR;
         end
         ST_CAR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = OP_CAR;
            ram_cmd.wr_data = '{phase: car_phase_nxt, level: env_out};
            rom_rd_en       = 1'b1;
            rom_addr        = car_phase_nxt[PHASE_W-1 -: AW];
            lvl_in          = ram_rd.level;
            state_in        = ST_SMP;
         end
         ST_SMP: begin
            // hold here until the output register can take the sample
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = SMP_MID + $unsigned(scaled);
               if (timer_ff != TIMER_MAX) begin
                  timer_in = timer_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         timer_ff     <= TIMER_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         timer_ff     <= timer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      fm_ff       <= fm_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         att_len_ff      <= ATTACK_LENGTH_RST;
         dec_len_ff      <= DECAY_LENGTH_RST;
         att_step_ff     <= ATTACK_STEP_RST;
         dec_step_ff     <= DECAY_STEP_RST;
         mod_att_len_ff  <= MOD_ATTACK_LENGTH_RST;
         mod_dec_len_ff  <= MOD_DECAY_LENGTH_RST;
         mod_att_step_ff <= MOD_ATTACK_STEP_RST;
         mod_dec_step_ff <= MOD_DECAY_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ATTACK_LENGTH:     att_len_ff      <= csr_data[LEN_W-1:0];
            REG_DECAY_LENGTH:      dec_len_ff      <= csr_data[LEN_W-1:0];
            REG_ATTACK_STEP:       att_step_ff     <= csr_data;
            REG_DECAY_STEP:        dec_step_ff     <= csr_data;
            REG_MOD_ATTACK_LENGTH: mod_att_len_ff  <= csr_data[LEN_W-1:0];
            REG_MOD_DECAY_LENGTH:  mod_dec_len_ff  <= csr_data[LEN_W-1:0];
            REG_MOD_ATTACK_STEP:   mod_att_step_ff <= csr_data;
            REG_MOD_DECAY_STEP:    mod_dec_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

endmodule
